// ===== src/rwct_pkg.sv =====
package rwct_pkg;

  localparam int STORE_DEPTH = 32768;
  localparam int STORE_AW    = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int DIV_STEPS   = 12;
  localparam int SHADE_MUL   = 288365;
  localparam int SHADE_SHIFT = 19;

  localparam logic [CFG_INDEX_W-1:0] CFG_TEXTURE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXTURE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERTICAL_OFFSET = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [14:0] texel_address;
    logic [31:0] texel_value;
    logic [9:0]  column;
    logic [6:0]  first_row;
    logic [6:0]  end_row;
    logic [15:0] slice_height;
    logic [15:0] hit_fraction;
    logic [2:0]  texture_id;
    logic        shade;
  } in_item_t;

  typedef struct packed {
    logic [9:0]        pixel_column;
    logic signed [7:0] pixel_row;
    logic [31:0]       pixel_color;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_SHADE,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic write_texel;
    logic load_item;
    logic setup;
    logic row_mul;
    logic div_step;
    logic addr_load;
    logic out_load;
    logic next_row;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last_row;
  } status_t;

endpackage

// ===== src/rwct_ctrl.sv =====
module rwct_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rwct_pkg::status_t sts,
  output rwct_pkg::cmd_t    cmd
);
  import rwct_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_DRAW) begin
            cmd.load_item = 1'b1;
            state_nxt     = ST_SETUP;
          end else begin
            cmd.write_texel = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.empty ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        cmd.row_mul = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt     = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_SHADE;
      end
      ST_SHADE: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_row = 1'b1;
            state_nxt    = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/rwct_datapath.sv =====
module rwct_datapath #(
  parameter int SCREEN_HEIGHT    = 64,
  parameter int TEXTURE_COUNT    = 8,
  parameter int TEXTURE_SIZE_MAX = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rwct_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [rwct_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rwct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  rwct_pkg::cmd_t                      cmd,
  output rwct_pkg::status_t                   sts,
  output rwct_pkg::out_item_t                 out_data
);
  import rwct_pkg::*;

  localparam int ROW_W    = $clog2(SCREEN_HEIGHT);
  localparam int TEX_AREA = TEXTURE_SIZE_MAX * TEXTURE_SIZE_MAX;
  localparam logic [6:0] SCR_H   = 7'(SCREEN_HEIGHT);
  localparam logic [6:0] TSM     = 7'(TEXTURE_SIZE_MAX);
  localparam logic [4:0] TEX_CNT = 5'(TEXTURE_COUNT);

  // configuration
  logic [6:0] width_r, height_r;
  logic signed [6:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd64;
      height_r <= 7'd64;
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEXTURE_WIDTH:   width_r  <= cfg_wdata;
        CFG_TEXTURE_HEIGHT:  height_r <= cfg_wdata;
        CFG_VERTICAL_OFFSET: offset_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  logic [6:0] w_eff, h_eff;
  logic [5:0] h_m1;

  always_comb begin
    w_eff = width_r;
    if (width_r == 7'd0) w_eff = 7'd1;
    else if (width_r > TSM) w_eff = TSM;
    h_eff = height_r;
    if (height_r == 7'd0) h_eff = 7'd1;
    else if (height_r > TSM) h_eff = TSM;
    h_m1 = 6'(h_eff - 7'd1);
  end

  // latched draw item
  logic [9:0]  col_r;
  logic [6:0]  start_r, end_raw_r, end_r;
  logic [15:0] div_r, hit_r;
  logic [2:0]  id_r;
  logic        shade_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      col_r     <= in_data.column;
      start_r   <= in_data.first_row;
      end_raw_r <= in_data.end_row;
      div_r     <= (in_data.slice_height == 16'd0) ? 16'd1 : in_data.slice_height;
      hit_r     <= in_data.hit_fraction;
      id_r      <= in_data.texture_id;
      shade_r   <= in_data.shade;
    end
  end

  // per column setup
  logic [6:0]  end_clamp;
  logic [4:0]  id_mod;
  logic [22:0] tcol_prod;
  logic [5:0]  tcol_r;
  logic [14:0] base_r;
  logic [ROW_W-1:0] y_r;

  always_comb begin
    end_clamp = (end_raw_r > SCR_H) ? SCR_H : end_raw_r;
    id_mod    = {2'b0, id_r};
    for (int i = 0; i < 8; i++) begin
      if (id_mod >= TEX_CNT) id_mod = id_mod - TEX_CNT;
    end
    tcol_prod = {7'b0, hit_r} * {16'b0, w_eff};
  end

  assign sts.empty    = (start_r >= end_clamp);
  assign sts.last_row = ((7'(y_r) + 7'd1) == end_r);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      end_r  <= end_clamp;
      tcol_r <= tcol_prod[21:16];
      base_r <= 15'({10'b0, id_mod} * 15'(TEX_AREA));
      y_r    <= start_r[ROW_W-1:0];
    end else if (cmd.next_row) begin
      y_r <= y_r + 1'b1;
    end
  end

  // row factor and serial division
  logic signed [18:0] factor;
  logic [23:0] dvd_r, dvd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] trial;
  logic        ge;

  assign factor = $signed(19'({y_r, 1'b0})) + $signed({3'b0, div_r})
                  - $signed(19'(SCREEN_HEIGHT));

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    for (int k = 0; k < 2; k++) begin
      trial   = {rem_nxt, dvd_nxt[23]};
      ge      = (trial >= {1'b0, div_r});
      trial   = ge ? (trial - {1'b0, div_r}) : trial;
      rem_nxt = trial[15:0];
      dvd_nxt = {dvd_nxt[22:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_mul) begin
      dvd_r <= (factor > 19'sd0) ? ({7'b0, factor[16:0]} * {17'b0, h_eff}) : '0;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  // texel address
  logic [5:0]  trow;
  logic [12:0] trow_off;
  logic [14:0] addr_r;

  always_comb begin
    trow     = (dvd_r[23:1] > 23'(h_m1)) ? h_m1 : dvd_r[6:1];
    trow_off = {7'b0, trow} * {6'b0, w_eff};
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_load) begin
      addr_r <= base_r + 15'(trow_off) + 15'(tcol_r);
    end
  end

  // texture store
  logic [31:0] tex_mem [STORE_DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.write_texel) begin
      tex_mem[in_data.texel_address] <= in_data.texel_value;
    end
    rd_data_r <= tex_mem[addr_r];
  end

  // shading and output register
  logic [31:0] color;
  logic [26:0] shade_prod [3];
  out_item_t   out_r;

  always_comb begin
    color = rd_data_r;
    for (int k = 0; k < 3; k++) begin
      shade_prod[k] = {19'b0, rd_data_r[8*k +: 8]} * 27'(SHADE_MUL);
      if (shade_r) color[8*k +: 8] = shade_prod[k][SHADE_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.pixel_column <= col_r;
      out_r.pixel_row    <= $signed(8'(y_r)) + 8'(offset_r);
      out_r.pixel_color  <= color;
      out_r.last         <= sts.last_row;
    end
  end

  assign out_data = out_r;

endmodule

// ===== src/raycast_wall_column_texturer_core.sv =====
// Raycaster wall column texturer. Texel writes (operation 0) go into a 32768 x 32 texture
// store. A draw item (operation 1) produces one pixel per row from first_row up to end_row
// (clamped to SCREEN_HEIGHT); the last pixel carries last = 1. Each row goes through a row
// multiply, a two-bit-per-cycle divider by slice_height, address, texture read, shading and
// the output state, where the pixel waits until out_ready takes it; one item is in work at
// a time. The texture store has no reset: reading a texel never written gives any value.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) belong in idle periods only.
module raycast_wall_column_texturer_core #(
  parameter int SCREEN_HEIGHT    = 64,
  parameter int TEXTURE_COUNT    = 8,
  parameter int TEXTURE_SIZE_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rwct_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rwct_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [rwct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rwct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rwct_pkg::*;

  cmd_t    cmd;
  status_t sts;

  rwct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwct_datapath #(
    .SCREEN_HEIGHT    (SCREEN_HEIGHT),
    .TEXTURE_COUNT    (TEXTURE_COUNT),
    .TEXTURE_SIZE_MAX (TEXTURE_SIZE_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ===== src/rwct_checker.sv =====
module rwct_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rwct_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rwct_pkg::out_item_t out_data
);
  import rwct_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: never ready while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // a column continues after a non-final pixel
  a_column_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> !in_ready)
    else $error("ready before last pixel of column");

  // texel write does not stall the input: it is ready again in the next cycle
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_WRITE |=> in_ready)
    else $error("texel write stalled input");

  // a draw transfer starts work
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_DRAW |=> !in_ready && !out_valid)
    else $error("draw item not taken into work");

endmodule

bind raycast_wall_column_texturer_core rwct_checker u_rwct_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rwct_pkg::*;

  localparam int SCREEN_HEIGHT     = 64;
  localparam int TEXTURE_SIZE_MAX  = 64;
  localparam int COLUMN_CYCLES_MAX = 1089;
  localparam int LONG_HOLD_CYCLES  = 3000;
  localparam int WATCHDOG_LIMIT    = 20000;
  localparam int MAX_REPORTS       = 200;

  class column_tracker;
    bit [31:0]  texels [STORE_DEPTH];
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    logic [6:0] offset_reg;
    out_item_t  pixels_due [$];
    int         errors;

    function new();
      width_reg  = 7'd64;
      height_reg = 7'd64;
      offset_reg = 7'd0;
      errors     = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [6:0] value);
      case (idx)
        CFG_TEXTURE_WIDTH:   width_reg = value;
        CFG_TEXTURE_HEIGHT:  height_reg = value;
        CFG_VERTICAL_OFFSET: offset_reg = value;
        default: ;
      endcase
    endfunction

    function int clamp_dim(logic [6:0] v);
      if (v == 0) return 1;
      if (v > TEXTURE_SIZE_MAX) return TEXTURE_SIZE_MAX;
      return int'(v);
    endfunction

    function int column_end(in_item_t it);
      return (it.end_row > SCREEN_HEIGHT) ? SCREEN_HEIGHT : int'(it.end_row);
    endfunction

    function logic [STORE_AW-1:0] texel_index(in_item_t it, int y);
      int w, h, divisor, factor, trow, tcol, hit, id;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      hit = it.hit_fraction;
      id = it.texture_id;
      divisor = (it.slice_height == 0) ? 1 : int'(it.slice_height);
      tcol = (hit * w) >> 16;
      factor = 2 * y - SCREEN_HEIGHT + divisor;
      trow = 0;
      if (factor > 0) begin
        trow = ((factor * h) / divisor) / 2;
        if (trow > h - 1) trow = h - 1;
      end
      return STORE_AW'(id * TEXTURE_SIZE_MAX * TEXTURE_SIZE_MAX + trow * w + tcol);
    endfunction

    function logic [31:0] darken(logic [31:0] c);
      logic [31:0] r;
      int b, k;
      r = c;
      for (k = 0; k < 3; k++) begin
        b = c[8*k +: 8];
        r[8*k +: 8] = 8'((b * 55) / 100);
      end
      return r;
    endfunction

    function void predict_pixels(in_item_t it);
      int y, start, stop, off;
      logic [31:0] color;
      out_item_t px;
      if (it.operation == OP_WRITE) begin
        texels[it.texel_address] = it.texel_value;
        return;
      end
      start = it.first_row;
      stop = column_end(it);
      off = $signed(offset_reg);
      for (y = start; y < stop; y++) begin
        color = texels[texel_index(it, y)];
        if (it.shade) color = darken(color);
        px.pixel_column = it.column;
        px.pixel_row = 8'(y + off);
        px.pixel_color = color;
        px.last = (y + 1 == stop);
        pixels_due.push_back(px);
      end
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: pixel with none due, expected nothing actual col %0d row %0d color %h",
                   $time, got.pixel_column, got.pixel_row, got.pixel_color);
        return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_column !== want.pixel_column)
        report("pixel_column", want.pixel_column, got.pixel_column);
      if (got.pixel_row !== want.pixel_row)
        report("pixel_row", want.pixel_row, got.pixel_row);
      if (got.pixel_color !== want.pixel_color)
        report("pixel_color", want.pixel_color, got.pixel_color);
      if (got.last !== want.last)
        report("last", want.last, got.last);
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  column_tracker tracker;
  bit            written [STORE_DEPTH];
  bit            idle_enable = 1'b1;
  bit            long_hold = 1'b0;
  int            items_sent = 0;
  int            quiet_cycles = 0;

  raycast_wall_column_texturer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.predict_pixels(in_data);
      if (out_valid && out_ready) tracker.check_pixel(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side
  initial begin
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic in_item_t random_fields();
    in_item_t it;
    it.operation     = 1'($urandom);
    it.texel_address = 15'($urandom);
    it.texel_value   = $urandom;
    it.column        = 10'($urandom);
    it.first_row     = 7'($urandom);
    it.end_row       = 7'($urandom);
    it.slice_height  = 16'($urandom);
    it.hit_fraction  = 16'($urandom);
    it.texture_id    = 3'($urandom);
    it.shade         = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_draw();
    in_item_t it;
    it = random_fields();
    it.operation = OP_DRAW;
    case ($urandom_range(0, 9))
      0: ;
      1: it.end_row = 7'($urandom_range(65, 127));
      default: begin
        it.first_row = 7'($urandom_range(0, 63));
        it.end_row = 7'($urandom_range(int'(it.first_row) + 1, 64));
      end
    endcase
    case ($urandom_range(0, 7))
      0: it.slice_height = '0;
      1, 2: ;
      default: it.slice_height = 16'($urandom_range(1, 160));
    endcase
    // reuse a few texture columns so most texels are already loaded
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 2))
        0: it.hit_fraction = 16'h0000;
        1: it.hit_fraction = 16'h8000;
        default: it.hit_fraction = 16'hFFFF;
      endcase
      it.texture_id = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic store_texel(input logic [STORE_AW-1:0] addr, input logic [31:0] value);
    in_item_t it;
    it = random_fields();
    it.operation = OP_WRITE;
    it.texel_address = addr;
    it.texel_value = value;
    written[addr] = 1'b1;
    send_item(it);
  endtask

  // load every texel the column will read before drawing it
  task automatic draw_column(input in_item_t it);
    int y, stop;
    logic [STORE_AW-1:0] addr;
    stop = tracker.column_end(it);
    for (y = it.first_row; y < stop; y++) begin
      addr = tracker.texel_index(it, y);
      if (!written[addr]) store_texel(addr, $urandom);
    end
    send_item(it);
  endtask

  task automatic directed_draw(input int col, input int start, input int stop, input int slice,
                               input int hit, input int id, input bit shade_on);
    in_item_t it;
    it = random_fields();
    it.operation = OP_DRAW;
    it.column = 10'(col);
    it.first_row = 7'(start);
    it.end_row = 7'(stop);
    it.slice_height = 16'(slice);
    it.hit_fraction = 16'(hit);
    it.texture_id = 3'(id);
    it.shade = shade_on;
    draw_column(it);
  endtask

  task automatic apply_config(input logic [6:0] width_val, input logic [6:0] height_val,
                              input logic [6:0] offset_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TEXTURE_WIDTH;
    cfg_wdata <= width_val;
    @(posedge clk);
    cfg_index <= CFG_TEXTURE_HEIGHT;
    cfg_wdata <= height_val;
    @(posedge clk);
    cfg_index <= CFG_VERTICAL_OFFSET;
    cfg_wdata <= offset_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(CFG_TEXTURE_WIDTH, width_val);
    tracker.set_register(CFG_TEXTURE_HEIGHT, height_val);
    tracker.set_register(CFG_VERTICAL_OFFSET, offset_val);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (COLUMN_CYCLES_MAX + 11) @(posedge clk);
  endtask

  initial begin
    int phase;
    int stop_at;
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    apply_config(7'd64, 7'd64, 7'd0);
    store_texel(15'd0, 32'h0000_0000);
    store_texel(15'h7FFF, 32'hFFFF_FFFF);
    directed_draw(0, 0, 64, 64, 0, 0, 1'b0);
    directed_draw(1023, 0, 64, 64, 0, 0, 1'b1);
    directed_draw(512, 0, 64, 0, 0, 0, 1'b0);
    directed_draw(3, 0, 64, 1, 65535, 7, 1'b1);
    directed_draw(4, 10, 54, 65535, 65535, 7, 1'b1);
    directed_draw(5, 20, 20, 40, 0, 0, 1'b0);
    directed_draw(6, 50, 10, 40, 0, 0, 1'b0);
    directed_draw(7, 127, 127, 40, 0, 0, 1'b0);
    directed_draw(8, 64, 127, 40, 0, 0, 1'b0);
    directed_draw(9, 60, 127, 128, 32768, 3, 1'b0);
    directed_draw(10, 63, 64, 100, 65535, 0, 1'b1);
    directed_draw(11, 0, 1, 2000, 100, 5, 1'b0);
    finish_phase();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_config(7'd1, 7'd1, 7'h60);
        1: apply_config(7'd8, 7'd16, 7'h20);
        2: apply_config(7'd0, 7'd0, 7'h40);
        3: apply_config(7'h7F, 7'h7F, 7'h3F);
        4: apply_config(7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)),
                        7'($urandom_range(0, 64) - 32));
        default: apply_config(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                              7'($urandom_range(0, 64) - 32));
      endcase
      if (phase == 1) long_hold = 1'b1;
      if (phase == 5) idle_enable = 1'b0;
      stop_at = items_sent + 40;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 6) == 0) store_texel(15'($urandom), $urandom);
        else draw_column(random_draw());
      end
      finish_phase();
    end

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rwct_pkg.sv
src/rwct_ctrl.sv
src/rwct_datapath.sv
src/raycast_wall_column_texturer_core.sv
src/rwct_checker.sv
dv/testbench.sv
